/* src/icef_pkg.sv */
// icef_pkg: shared types and constants for the ICMP echo flood limiter.
// Holds frame offsets, protocol codes, verdict codes and the queue record type.
// No dependencies.
`default_nettype none

package icef_pkg;

  localparam int MAX_FRAME_BYTES = 16384;
  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

  localparam int TIME_W = 64;
  localparam int MFS_W = 15;
  localparam int MPW_W = 16;
  localparam int WL_W = 40;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 40;
  localparam int COUNT_W = 16;
  localparam int REASON_W = 3;

  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_MAX_FRAME = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_MAX_PER_WIN = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_WIN_LEN = 2'd2;

  localparam logic [MFS_W-1:0] MAX_FRAME_RST = 15'd1000;
  localparam logic [MPW_W-1:0] MAX_PER_WIN_RST = 16'd100;
  localparam logic [WL_W-1:0] WIN_LEN_RST = 40'd1000000000;

  localparam logic [POS_W-1:0] POS_ETYPE_HI = POS_W'(12);
  localparam logic [POS_W-1:0] POS_ETYPE_LO = POS_W'(13);
  localparam logic [POS_W-1:0] POS_PROTO = POS_W'(23);
  localparam logic [POS_W-1:0] POS_ICMP_TYPE = POS_W'(34);
  localparam logic [POS_W-1:0] MIN_CHECKED_LEN = POS_W'(42);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] ICMP_ECHO_REQ = 8'd8;

  localparam logic [REASON_W-1:0] REASON_NOT_ECHO = 3'd0;
  localparam logic [REASON_W-1:0] REASON_COUNTED = 3'd1;
  localparam logic [REASON_W-1:0] REASON_RESTART = 3'd2;
  localparam logic [REASON_W-1:0] REASON_OVERSIZE = 3'd3;
  localparam logic [REASON_W-1:0] REASON_RATE = 3'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_OTHER,
    KIND_OVERSIZE,
    KIND_ECHO
  } frame_kind_t;

  typedef struct packed {
    frame_kind_t kind;
    logic [TIME_W-1:0] frame_time;
  } frame_rec_t;

  typedef struct packed {
    logic [MFS_W-1:0] max_frame_size;
    logic [MPW_W-1:0] max_per_window;
    logic [WL_W-1:0] window_length;
  } cfg_t;

endpackage

`default_nettype wire

/* src/icef_front.sv */
// icef_front: byte parser that captures header fields and classifies each frame.
// Pushes one record per frame into the verdict queue on the last byte.
// Depends on icef_pkg.
`default_nettype none

module icef_front
  import icef_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  input  wire logic [TIME_W-1:0] arrival_time,
  input  wire logic [MFS_W-1:0]  max_frame_size,
  output logic                   push,
  output frame_rec_t             rec
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [15:0]       etype_r, etype_nxt;
  logic [7:0]        proto_r, proto_nxt;
  logic [7:0]        icmp_r, icmp_nxt;
  logic [TIME_W-1:0] ftime_r;
  logic [POS_W-1:0]  len;
  logic              is_echo;

  assign len = (pos_r < POS_MAX) ? pos_r + POS_W'(1) : pos_r;

  assign is_echo = (len >= MIN_CHECKED_LEN) && (etype_r == ETH_IPV4) &&
                   (proto_r == PROTO_ICMP) && (icmp_r == ICMP_ECHO_REQ);

  always_comb begin
    etype_nxt = etype_r;
    proto_nxt = proto_r;
    icmp_nxt = icmp_r;
    pos_nxt = len;
    if (pos_r == POS_ETYPE_HI) begin
      etype_nxt = {data_byte, etype_r[7:0]};
    end else if (pos_r == POS_ETYPE_LO) begin
      etype_nxt = {etype_r[15:8], data_byte};
    end else if (pos_r == POS_PROTO) begin
      proto_nxt = data_byte;
    end else if (pos_r == POS_ICMP_TYPE) begin
      icmp_nxt = data_byte;
    end
    if (last_byte) begin
      pos_nxt = '0;
      etype_nxt = '0;
      proto_nxt = '0;
      icmp_nxt = '0;
    end
  end

  always_comb begin
    push = acc && last_byte;
    rec.frame_time = (pos_r == '0) ? arrival_time : ftime_r;
    if (!is_echo) begin
      rec.kind = KIND_OTHER;
    end else if ({1'b0, len} > {{(POS_W + 1 - MFS_W){1'b0}}, max_frame_size}) begin
      rec.kind = KIND_OVERSIZE;
    end else begin
      rec.kind = KIND_ECHO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      etype_r <= '0;
      proto_r <= '0;
      icmp_r <= '0;
    end else if (acc) begin
      pos_r <= pos_nxt;
      etype_r <= etype_nxt;
      proto_r <= proto_nxt;
      icmp_r <= icmp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && pos_r == '0) begin
      ftime_r <= arrival_time;
    end
  end

endmodule

`default_nettype wire

/* src/icef_queue.sv */
// icef_queue: short record queue between the parser and the window limiter.
// Circular buffer with registered pointers and fill count.
// Depends on icef_pkg.
`default_nettype none

module icef_queue
  import icef_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire frame_rec_t push_rec,
  input  wire logic       pop,
  output frame_rec_t      head_rec,
  output logic            not_empty,
  output logic            full
);

  frame_rec_t        mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign not_empty = (count_r != '0);
  assign full = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_rec = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with unequal pointers");
`endif

endmodule

`default_nettype wire

/* src/icef_back.sv */
// icef_back: single-entry fixed-window limiter and verdict output register.
// Pops frame records from the queue and issues one verdict per record.
// Depends on icef_pkg.
`default_nettype none

module icef_back
  import icef_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cfg_t                cfg,
  input  wire frame_rec_t          head_rec,
  input  wire logic                not_empty,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_drop,
  output logic [REASON_W-1:0]      out_reason,
  output logic [COUNT_W-1:0]       out_count
);

  logic                win_valid_r;
  logic [TIME_W-1:0]   win_start_r;
  logic [COUNT_W-1:0]  win_pkts_r, win_pkts_nxt;
  logic                out_valid_r;
  logic                out_drop_r, drop_nxt;
  logic [REASON_W-1:0] out_reason_r, reason_nxt;
  logic [COUNT_W-1:0]  out_count_r;
  logic [TIME_W-1:0]   elapsed;
  logic                expired;
  logic                restart;

  assign pop = not_empty && (!out_valid_r || out_ready);
  assign elapsed = head_rec.frame_time - win_start_r;
  assign expired = elapsed >= {{(TIME_W - WL_W){1'b0}}, cfg.window_length};

  always_comb begin
    drop_nxt = 1'b0;
    reason_nxt = REASON_NOT_ECHO;
    win_pkts_nxt = win_pkts_r;
    restart = 1'b0;
    unique case (head_rec.kind)
      KIND_OVERSIZE: begin
        drop_nxt = 1'b1;
        reason_nxt = REASON_OVERSIZE;
      end
      KIND_ECHO: begin
        if (!win_valid_r || expired) begin
          restart = 1'b1;
          win_pkts_nxt = COUNT_W'(1);
          reason_nxt = REASON_RESTART;
        end else if (win_pkts_r >= cfg.max_per_window) begin
          drop_nxt = 1'b1;
          reason_nxt = REASON_RATE;
        end else begin
          win_pkts_nxt = win_pkts_r + COUNT_W'(1);
          reason_nxt = REASON_COUNTED;
        end
      end
      default: begin
        reason_nxt = REASON_NOT_ECHO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_valid_r <= 1'b0;
      win_start_r <= '0;
      win_pkts_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        win_pkts_r <= win_pkts_nxt;
        if (restart) begin
          win_valid_r <= 1'b1;
          win_start_r <= head_rec.frame_time;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_drop_r <= drop_nxt;
      out_reason_r <= reason_nxt;
      out_count_r <= win_pkts_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_drop = out_drop_r;
  assign out_reason = out_reason_r;
  assign out_count = out_count_r;

`ifndef SYNTH
  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r)
    else $error("popped record not presented");
  a_win_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(win_valid_r))
    else $error("window valid cleared outside reset");
  a_restart_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_reason_r == REASON_RESTART) |-> (out_count_r == COUNT_W'(1)))
    else $error("restart verdict without count of one");
`endif

endmodule

`default_nettype wire

/* src/icmp_echo_flood_limiter.sv */
// icmp_echo_flood_limiter: ICMP echo request flood limiter, top level.
// Holds the configuration registers; instantiates icef_front, icef_queue, icef_back.
// Depends on icef_pkg.
//
// Usage:
//   Input stream carries one Ethernet frame byte per transaction, tlast on the
//   final byte; the timestamp in tdata is sampled on the first byte.
//   Output stream carries one verdict transaction per frame, issued for the
//   last byte: drop flag, reason code and window count.
//   Throughput: one byte per cycle sustained while the record queue has room; frames may follow back to back.
//   A verdict passes through the record queue and then the verdict output register;
//   out_tvalid rises once the last byte's record has been popped from the queue.
//   A four-entry record queue decouples the byte parser from the limiter;
//   in_tready falls only when that queue is full, i.e. when the receiver has
//   stalled out_tready for several frame ends. A stalled verdict holds.
//   Configuration: cfg_wen writes register cfg_addr (0 max frame size,
//   1 max requests per window, 2 window length in ns); write only while no
//   frame is in flight.
//   Reset (synchronous, rst_n low): registers load their defaults, the parser
//   restarts at byte zero, the queue empties and no window exists yet.
`default_nettype none

module icmp_echo_flood_limiter
  import icef_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [71:0]           in_tdata,   // data_byte[7:0], arrival_time[71:8]
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [23:0]                out_tdata,  // drop[0], verdict_reason[3:1],
                                                 // window_count[19:4], zero[23:20]
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                cfg_r;
  logic                acc;
  logic                push;
  frame_rec_t          push_rec;
  frame_rec_t          head_rec;
  logic                pop;
  logic                not_empty;
  logic                full;
  logic                v_drop;
  logic [REASON_W-1:0] v_reason;
  logic [COUNT_W-1:0]  v_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_frame_size <= MAX_FRAME_RST;
      cfg_r.max_per_window <= MAX_PER_WIN_RST;
      cfg_r.window_length <= WIN_LEN_RST;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        CFG_IDX_MAX_FRAME:   cfg_r.max_frame_size <= cfg_wdata[MFS_W-1:0];
        CFG_IDX_MAX_PER_WIN: cfg_r.max_per_window <= cfg_wdata[MPW_W-1:0];
        CFG_IDX_WIN_LEN:     cfg_r.window_length <= cfg_wdata[WL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_tready = !full;
  assign acc = in_tvalid && in_tready;

  icef_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (acc),
    .data_byte      (in_tdata[7:0]),
    .last_byte      (in_tlast),
    .arrival_time   (in_tdata[71:8]),
    .max_frame_size (cfg_r.max_frame_size),
    .push           (push),
    .rec            (push_rec)
  );

  icef_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .head_rec  (head_rec),
    .not_empty (not_empty),
    .full      (full)
  );

  icef_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_rec   (head_rec),
    .not_empty  (not_empty),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_drop   (v_drop),
    .out_reason (v_reason),
    .out_count  (v_count)
  );

  assign out_tdata = {4'b0000, v_count, v_reason, v_drop};

endmodule

`default_nettype wire

/* bench/tb_icmp_echo_flood_limiter.sv */
// tb_icmp_echo_flood_limiter: self-checking bench for the ICMP echo flood limiter.
// Streams byte-wise frames through the block, predicts each verdict from a local
// model of the header capture and the fixed window, and compares it. Uses icef_pkg.
`default_nettype none

module tb_icmp_echo_flood_limiter;
  import icef_pkg::*;

  typedef struct packed {
    logic                drop;
    logic [REASON_W-1:0] reason;
    logic [COUNT_W-1:0]  count;
  } verdict_t;

  typedef enum int {
    SHAPE_ECHO,
    SHAPE_BAD_ETYPE_HI,
    SHAPE_BAD_ETYPE_LO,
    SHAPE_BAD_PROTO,
    SHAPE_BAD_TYPE,
    SHAPE_NOISE
  } frame_shape_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [71:0]           in_tdata = '0;  // data_byte[7:0], arrival_time[71:8]
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;      // drop[0], verdict_reason[3:1],
                                         // window_count[19:4], zero[23:20]
  logic                  cfg_wen = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  icmp_echo_flood_limiter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Limiter shadow: configuration
  logic [MFS_W-1:0]  size_limit = MAX_FRAME_RST;
  logic [MPW_W-1:0]  burst_limit = MAX_PER_WIN_RST;
  logic [WL_W-1:0]   window_ns = WIN_LEN_RST;
  // Limiter shadow: parser and window
  int                byte_pos = 0;
  logic [15:0]       etype = '0;
  logic [7:0]        ip_proto = '0;
  logic [7:0]        icmp_msg = '0;
  logic [63:0]       frame_ts = '0;
  bit                window_open = 1'b0;
  logic [63:0]       window_ts = '0;
  logic [15:0]       window_pkts = '0;

  verdict_t          verdict_q[$];
  logic [7:0]        frame_buf[$];
  int                mismatches = 0;
  int                bytes_sent = 0;
  int                tx_gap_pct = 23;
  int                rx_stall_pct = 50;
  int                hold_cycles = 0;
  logic [63:0]       now = '0;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic predict_byte(input logic [7:0] b, input bit last, input logic [63:0] ts);
    verdict_t v;
    if (byte_pos == 0) frame_ts = ts;
    if (byte_pos == POS_ETYPE_HI) etype[15:8] = b;
    else if (byte_pos == POS_ETYPE_LO) etype[7:0] = b;
    else if (byte_pos == POS_PROTO) ip_proto = b;
    else if (byte_pos == POS_ICMP_TYPE) icmp_msg = b;
    if (byte_pos < MAX_FRAME_BYTES) byte_pos++;
    if (last) begin
      v.drop = 1'b0;
      v.reason = REASON_NOT_ECHO;
      if (byte_pos >= MIN_CHECKED_LEN && etype == ETH_IPV4 && ip_proto == PROTO_ICMP &&
          icmp_msg == ICMP_ECHO_REQ) begin
        if (byte_pos > size_limit) begin
          v.drop = 1'b1;
          v.reason = REASON_OVERSIZE;
        end else if (!window_open || (frame_ts - window_ts) >= {24'd0, window_ns}) begin
          window_open = 1'b1;
          window_ts = frame_ts;
          window_pkts = 16'd1;
          v.reason = REASON_RESTART;
        end else if (window_pkts >= burst_limit) begin
          v.drop = 1'b1;
          v.reason = REASON_RATE;
        end else begin
          window_pkts = window_pkts + 16'd1;
          v.reason = REASON_COUNTED;
        end
      end
      v.count = window_pkts;
      verdict_q.push_back(v);
      byte_pos = 0;
      etype = '0;
      ip_proto = '0;
      icmp_msg = '0;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input bit last, input logic [63:0] ts);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ts, b};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_byte(b, last, ts);
    bytes_sent++;
  endtask

  task automatic make_frame(input int len, input frame_shape_t shape);
    frame_buf.delete();
    for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom));
    if (shape == SHAPE_NOISE) return;
    if (len > POS_ETYPE_HI) frame_buf[POS_ETYPE_HI] = ETH_IPV4[15:8];
    if (len > POS_ETYPE_LO) frame_buf[POS_ETYPE_LO] = ETH_IPV4[7:0];
    if (len > POS_PROTO) frame_buf[POS_PROTO] = PROTO_ICMP;
    if (len > POS_ICMP_TYPE) frame_buf[POS_ICMP_TYPE] = ICMP_ECHO_REQ;
    case (shape)
      SHAPE_BAD_ETYPE_HI: if (len > POS_ETYPE_HI)
        frame_buf[POS_ETYPE_HI] = ETH_IPV4[15:8] ^ 8'($urandom_range(1, 255));
      SHAPE_BAD_ETYPE_LO: if (len > POS_ETYPE_LO)
        frame_buf[POS_ETYPE_LO] = ETH_IPV4[7:0] ^ 8'($urandom_range(1, 255));
      SHAPE_BAD_PROTO: if (len > POS_PROTO)
        frame_buf[POS_PROTO] = PROTO_ICMP ^ 8'($urandom_range(1, 255));
      SHAPE_BAD_TYPE: if (len > POS_ICMP_TYPE)
        frame_buf[POS_ICMP_TYPE] = ICMP_ECHO_REQ ^ 8'($urandom_range(1, 255));
      default: ;
    endcase
  endtask

  task automatic send_frame(input logic [63:0] ts);
    for (int i = 0; i < frame_buf.size(); i++)
      send_byte(frame_buf[i], i == frame_buf.size() - 1, i == 0 ? ts : rand64());
  endtask

  task automatic send_shaped(input int len, input frame_shape_t shape, input logic [63:0] ts);
    make_frame(len, shape);
    send_frame(ts);
  endtask

  // Hold the input idle until every verdict is back, then cover the pipeline tail.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      CFG_IDX_MAX_FRAME:   size_limit = val[MFS_W-1:0];
      CFG_IDX_MAX_PER_WIN: burst_limit = val[MPW_W-1:0];
      CFG_IDX_WIN_LEN:     window_ns = val[WL_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_verdict
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected verdict, expected none actual %h", $time, out_tdata);
      end else begin
        want = verdict_q.pop_front();
        if (out_tdata[0] !== want.drop) begin
          mismatches++;
          $display("%0t: drop expected %0d actual %0d", $time, want.drop, out_tdata[0]);
        end
        if (out_tdata[3:1] !== want.reason) begin
          mismatches++;
          $display("%0t: reason expected %0d actual %0d", $time, want.reason, out_tdata[3:1]);
        end
        if (out_tdata[19:4] !== want.count) begin
          mismatches++;
          $display("%0t: window count expected %0d actual %0d", $time, want.count,
                   out_tdata[19:4]);
        end
      end
    end
  end

  task automatic test_header_parsing();
    send_shaped(1, SHAPE_NOISE, rand64());
    send_shaped(41, SHAPE_ECHO, 64'd900);
    send_shaped(42, SHAPE_ECHO, 64'd1000);
    send_shaped(42, SHAPE_BAD_PROTO, 64'd1013);
    send_shaped(3, SHAPE_NOISE, 64'd1015);
  endtask

  task automatic test_size_limit();
    write_reg(CFG_IDX_MAX_FRAME, 40'd41);
    send_shaped(42, SHAPE_ECHO, 64'd1016);
    write_reg(CFG_IDX_MAX_FRAME, 40'd42);
    send_shaped(42, SHAPE_ECHO, 64'd1020);
    write_reg(CFG_IDX_MAX_FRAME, 40'd16384);
  endtask

  task automatic test_window_limit();
    write_reg(CFG_IDX_MAX_PER_WIN, 40'd1);
    write_reg(CFG_IDX_WIN_LEN, 40'd100);
    send_shaped(42, SHAPE_ECHO, 64'd5000);
    send_shaped(42, SHAPE_ECHO, 64'd5050);
    send_shaped(42, SHAPE_ECHO, 64'd5100);
    write_reg(CFG_IDX_MAX_PER_WIN, 40'd65535);
    write_reg(CFG_IDX_WIN_LEN, 40'hFF_FFFF_FFFF);
    send_shaped(42, SHAPE_ECHO, 64'hFFFF_FFFF_FFFF_FFFB);
    send_shaped(42, SHAPE_ECHO, 64'd3);
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 30; i++)
      send_shaped($urandom_range(1, 3), SHAPE_NOISE, rand64());
    wait_drained();
  endtask

  task automatic pick_config();
    logic [CFG_DATA_W-1:0] w;
    w = CFG_DATA_W'(rand64());
    case ($urandom_range(9))
      0: w[MFS_W-1:0] = 15'd0;
      1: w[MFS_W-1:0] = 15'd16384;
      2: w[MFS_W-1:0] = 15'($urandom_range(0, 16384));
      default: w[MFS_W-1:0] = 15'($urandom_range(42, 50));
    endcase
    write_reg(CFG_IDX_MAX_FRAME, w);
    w = CFG_DATA_W'(rand64());
    case ($urandom_range(9))
      0: w[MPW_W-1:0] = 16'd65535;
      1: w[MPW_W-1:0] = 16'd1;
      2: w[MPW_W-1:0] = 16'd0;
      default: w[MPW_W-1:0] = 16'($urandom_range(1, 6));
    endcase
    write_reg(CFG_IDX_MAX_PER_WIN, w);
    case ($urandom_range(9))
      0: w = 40'hFF_FFFF_FFFF;
      1: w = 40'd1;
      2: w = 40'd0;
      default: w = 40'($urandom_range(1, 200));
    endcase
    write_reg(CFG_IDX_WIN_LEN, w);
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct);
    int b0;
    int r;
    tx_gap_pct = tx_pct;
    rx_stall_pct = rx_pct;
    pick_config();
    b0 = bytes_sent;
    while (bytes_sent - b0 < 60) begin
      if ($urandom_range(24) == 0) now = rand64();
      else now = now + $urandom_range(0, 80);
      r = $urandom_range(99);
      if (r < 30)
        send_shaped($urandom_range(9) == 0 ? $urandom_range(35, 41) : $urandom_range(42, 48),
                    SHAPE_ECHO, now);
      else if (r < 45)
        send_shaped($urandom_range(42, 48), frame_shape_t'($urandom_range(1, 4)), now);
      else if (r < 90)
        send_shaped($urandom_range(1, 8), SHAPE_NOISE, now);
      else
        send_shaped($urandom_range(9, 48), SHAPE_NOISE, now);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_header_parsing();
    test_size_limit();
    test_window_limit();
    test_backpressure();
    test_random_traffic(23, 50);
    test_random_traffic(50, 23);
    test_random_traffic(0, 0);
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #16000000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
